### rtl/core/coap_pkg.sv
// ----------------------------------------------------------------------------
// CoAP message parser package
// Shared types and constants: parse phases, byte kinds, error codes,
// register indexes, the running parse state and the configuration bundle.
// ----------------------------------------------------------------------------
package coap_pkg;

  localparam logic [3:0] MAX_TOKEN_LEN = 4'd8;

  // Option nibble codes
  localparam logic [3:0] NIB_DIRECT_MAX = 4'd12;
  localparam logic [3:0] NIB_EXT8       = 4'd13;
  localparam logic [3:0] NIB_RESERVED   = 4'd15;

  localparam logic [15:0] EXT8_OFFSET  = 16'd13;
  localparam logic [15:0] EXT16_OFFSET = 16'd269;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_TOKEN,
    PH_OPTHDR,
    PH_DEXT,
    PH_LEXT,
    PH_VALUE,
    PH_PAYLOAD,
    PH_IGNORE
  } phase_t;

  typedef enum logic [3:0] {
    KIND_HDR     = 4'd0,
    KIND_CODE    = 4'd1,
    KIND_MSGID   = 4'd2,
    KIND_TOKEN   = 4'd3,
    KIND_OPTHDR  = 4'd4,
    KIND_OPTEXT  = 4'd5,
    KIND_OPTVAL  = 4'd6,
    KIND_MARKER  = 4'd7,
    KIND_PAYLOAD = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_SHORT,
    ERR_TKL,
    ERR_NIBBLE15,
    ERR_OVERFLOW,
    ERR_TRUNCATED,
    ERR_NOPAYLOAD,
    ERR_TOOLONG
  } err_t;

  typedef enum logic {
    REG_CAPTURE_COUNT,
    REG_VALUE_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  capture_count;
    logic [15:0] value_limit;
  } cfg_t;

  // All-zero value is the state at the start of a datagram.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hdr_pos;
    logic [3:0]  token_left;
    logic [3:0]  tkl;
    logic [3:0]  delta_nib;
    logic [3:0]  length_nib;
    logic [15:0] ext_accum;
    logic [1:0]  ext_left;
    logic [15:0] delta_val;
    logic [15:0] running_number;
    logic [15:0] current_length;
    logic [15:0] value_left;
    logic [7:0]  option_count;
    logic [7:0]  cur_index;
    logic [16:0] area_bytes;
    err_t        error;
  } parse_state_t;

endpackage

### rtl/core/coap_message_parser_top.sv
// ----------------------------------------------------------------------------
// CoAP message parser top level
// Byte-serial classifier for CoAP datagrams with option tracking.
// ----------------------------------------------------------------------------
// Feed one datagram byte per transaction with last_byte set on the final
// byte; every byte gives exactly one result transaction, in order. The block
// takes one byte per clock cycle sustained while result_stall stays low. An
// accepted byte sits in the input register while a combinational update of
// the running parse state computes its result, which lands in the result
// register when that register is empty or its transaction completes.
// That state update, one byte deep, is what sets the rate. Either
// side may stall at any time; the input register and result register keep
// the stream lossless. Configuration writes belong in idle periods (no
// result outstanding); they take effect for the next byte processed. The
// parse state clears itself after every last byte, registers are kept.
// ----------------------------------------------------------------------------
module coap_message_parser_top (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  byte_kind,
  output logic [7:0]  byte_value,
  output logic [15:0] option_number,
  output logic [15:0] option_length,
  output logic [7:0]  option_index,
  output logic [3:0]  token_size,
  output logic        message_done,
  output logic [2:0]  error_code,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import coap_pkg::*;

  cfg_t         cfg;
  parse_state_t state;
  parse_state_t state_next;
  kind_t        kind;

  // Input register
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;

  coap_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  coap_step u_step (
    .st        (state),
    .cfg       (cfg),
    .data_byte (in_byte),
    .last_byte (in_last),
    .st_next   (state_next),
    .kind      (kind)
  );

  // Move the held byte into the result register whenever that register is
  // empty or its transaction completes this cycle.
  assign advance    = in_valid && (!result_valid || !result_stall);
  assign data_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  // Parse state: advance per byte, clear after the datagram's last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= in_last ? parse_state_t'('0) : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload reflects the state after this byte, before any clear.
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_kind     <= kind;
      byte_value    <= in_byte;
      option_number <= state_next.running_number;
      option_length <= state_next.current_length;
      option_index  <= state_next.cur_index;
      token_size    <= state_next.tkl;
      message_done  <= in_last;
      error_code    <= state_next.error;
    end
  end

endmodule

### rtl/core/coap_cfg_regs.sv
// ----------------------------------------------------------------------------
// CoAP parser configuration registers
// APB-style register file: capture count and option value length limit.
// ----------------------------------------------------------------------------
module coap_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output coap_pkg::cfg_t     cfg
);
  import coap_pkg::*;

  reg_idx_t reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capture_count <= 8'd0;
      cfg.value_limit   <= 16'd12;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CAPTURE_COUNT: cfg.capture_count <= pwdata[7:0];
        REG_VALUE_LIMIT:   cfg.value_limit   <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPTURE_COUNT: prdata = {24'd0, cfg.capture_count};
      REG_VALUE_LIMIT:   prdata = {16'd0, cfg.value_limit};
    endcase
  end

endmodule

### rtl/core/coap_step.sv
// ----------------------------------------------------------------------------
// CoAP parser step logic
// Classifies one byte and computes the parse state that follows it.
// ----------------------------------------------------------------------------
module coap_step (
  input  coap_pkg::parse_state_t st,
  input  coap_pkg::cfg_t         cfg,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output coap_pkg::parse_state_t st_next,
  output coap_pkg::kind_t        kind
);
  import coap_pkg::*;

  function automatic parse_state_t fail(parse_state_t s, err_t code);
    s.error = code;
    s.phase = PH_IGNORE;
    return s;
  endfunction

  function automatic parse_state_t start_ext(parse_state_t s, logic [3:0] nib, phase_t nxt);
    s.ext_accum = 16'd0;
    s.ext_left  = (nib == NIB_EXT8) ? 2'd1 : 2'd2;
    s.phase     = nxt;
    return s;
  endfunction

  function automatic logic [15:0] ext_value(logic [15:0] accum, logic [3:0] nib);
    return accum + ((nib == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET);
  endfunction

  function automatic parse_state_t complete_opt(parse_state_t s, logic [15:0] len,
                                                logic last, cfg_t c);
    logic [16:0] num_sum;
    logic [16:0] area_sum;
    num_sum  = {1'b0, s.running_number} + {1'b0, s.delta_val};
    area_sum = s.area_bytes + {1'b0, len};
    if (num_sum[16] || s.area_bytes[16] || area_sum[16]) begin
      s = fail(s, ERR_OVERFLOW);
    end else begin
      s.running_number = num_sum[15:0];
      s.current_length = len;
      if (last && (len != 16'd0)) begin
        s = fail(s, ERR_TRUNCATED);
      end else if ((s.cur_index < c.capture_count) && (len > c.value_limit)) begin
        s = fail(s, ERR_TOOLONG);
      end else if (len == 16'd0) begin
        s.phase = PH_OPTHDR;
      end else begin
        s.value_left = len;
        s.area_bytes = area_sum;
        s.phase      = PH_VALUE;
      end
    end
    return s;
  endfunction

  function automatic parse_state_t after_delta(parse_state_t s, logic [15:0] delta,
                                               logic last, logic from_ext, cfg_t c);
    s.delta_val = delta;
    if (s.length_nib > NIB_DIRECT_MAX) begin
      if ((s.length_nib == NIB_RESERVED) && !(last && from_ext)) begin
        s = fail(s, ERR_NIBBLE15);
      end else if (last) begin
        s = fail(s, ERR_TRUNCATED);
      end else begin
        s = start_ext(s, s.length_nib, PH_LEXT);
      end
    end else begin
      s = complete_opt(s, {12'd0, s.length_nib}, last, c);
    end
    return s;
  endfunction

  logic [15:0] accum_shift;
  logic [1:0]  ext_left_dec;
  logic [16:0] area_inc;

  assign accum_shift  = {st.ext_accum[7:0], data_byte};
  assign ext_left_dec = (st.ext_left != 2'd0) ? st.ext_left - 2'd1 : 2'd0;
  // Area count saturates just above the 16-bit limit.
  assign area_inc     = st.area_bytes[16] ? st.area_bytes : st.area_bytes + 17'd1;

  always_comb begin
    st_next = st;
    kind    = KIND_PAYLOAD;
    unique case (st.phase)
      PH_HDR: begin
        if (st.hdr_pos == 2'd0) begin
          kind        = KIND_HDR;
          st_next.tkl = data_byte[3:0];
        end else if (st.hdr_pos == 2'd1) begin
          kind = KIND_CODE;
        end else begin
          kind = KIND_MSGID;
        end
        if (st.hdr_pos != 2'd3) begin
          st_next.hdr_pos = st.hdr_pos + 2'd1;
          if (last_byte) st_next = fail(st_next, ERR_SHORT);
        end else if (st.tkl > MAX_TOKEN_LEN) begin
          st_next = fail(st_next, ERR_TKL);
        end else if (st.tkl == 4'd0) begin
          st_next.phase = PH_OPTHDR;
        end else if (last_byte) begin
          st_next = fail(st_next, ERR_SHORT);
        end else begin
          st_next.token_left = st.tkl;
          st_next.phase      = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        kind               = KIND_TOKEN;
        st_next.token_left = st.token_left - 4'd1;
        if (st_next.token_left == 4'd0) begin
          st_next.phase = PH_OPTHDR;
        end else if (last_byte) begin
          st_next = fail(st_next, ERR_SHORT);
        end
      end
      PH_OPTHDR: begin
        kind               = KIND_OPTHDR;
        st_next.area_bytes = area_inc;
        if (data_byte == MARKER_BYTE) begin
          kind = KIND_MARKER;
          if (last_byte) st_next = fail(st_next, ERR_NOPAYLOAD);
          else           st_next.phase = PH_PAYLOAD;
        end else begin
          st_next.cur_index  = st.option_count;
          if (st.option_count != 8'hFF) st_next.option_count = st.option_count + 8'd1;
          st_next.delta_nib  = data_byte[7:4];
          st_next.length_nib = data_byte[3:0];
          if (last_byte && (data_byte[7:4] > NIB_DIRECT_MAX)) begin
            st_next = fail(st_next, ERR_TRUNCATED);
          end else if (data_byte[7:4] == NIB_RESERVED) begin
            st_next = fail(st_next, ERR_NIBBLE15);
          end else if (data_byte[7:4] > NIB_DIRECT_MAX) begin
            st_next = start_ext(st_next, data_byte[7:4], PH_DEXT);
          end else begin
            st_next = after_delta(st_next, {12'd0, data_byte[7:4]}, last_byte, 1'b0, cfg);
          end
        end
      end
      PH_DEXT, PH_LEXT: begin
        kind               = KIND_OPTEXT;
        st_next.area_bytes = area_inc;
        st_next.ext_accum  = accum_shift;
        st_next.ext_left   = ext_left_dec;
        if (ext_left_dec != 2'd0) begin
          if (last_byte) st_next = fail(st_next, ERR_TRUNCATED);
        end else if (st.phase == PH_DEXT) begin
          st_next = after_delta(st_next, ext_value(accum_shift, st.delta_nib),
                                last_byte, 1'b1, cfg);
        end else begin
          st_next = complete_opt(st_next, ext_value(accum_shift, st.length_nib),
                                 last_byte, cfg);
        end
      end
      PH_VALUE: begin
        kind = KIND_OPTVAL;
        if (st.value_left != 16'd0) st_next.value_left = st.value_left - 16'd1;
        if (st_next.value_left == 16'd0) begin
          st_next.phase = PH_OPTHDR;
        end else if (last_byte) begin
          st_next = fail(st_next, ERR_TRUNCATED);
        end
      end
      PH_PAYLOAD, PH_IGNORE: begin
        kind = KIND_PAYLOAD;
      end
    endcase
  end

endmodule

### rtl/core/coap_checker.sv
// ----------------------------------------------------------------------------
// CoAP parser port checker
// Concurrent checks on the top level's result channel, bound to the top.
// ----------------------------------------------------------------------------
module coap_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [3:0]  byte_kind,
  input logic [7:0]  byte_value,
  input logic [15:0] option_number,
  input logic [15:0] option_length,
  input logic [7:0]  option_index,
  input logic [3:0]  token_size,
  input logic [2:0]  error_code
);
  import coap_pkg::*;

  // Hold a stalled result transaction.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(byte_kind) && $stable(byte_value) && $stable(error_code))
    else $error("stalled result changed");

  // First header byte starts from a cleared option state.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_kind == KIND_HDR) |->
      (option_number == 16'd0) && (option_length == 16'd0) && (option_index == 8'd0))
    else $error("option state not cleared at datagram start");

  // Token bytes only exist for a legal, nonzero token length.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_kind == KIND_TOKEN) |->
      (token_size != 4'd0) && (token_size <= MAX_TOKEN_LEN))
    else $error("token byte with illegal token length");

  // A value byte belongs to an option with nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_kind == KIND_OPTVAL) |-> (option_length != 16'd0))
    else $error("value byte for empty option");

  // A marker is clean unless it ends the datagram.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (byte_kind == KIND_MARKER) |->
      (error_code == ERR_NONE) || (error_code == ERR_NOPAYLOAD))
    else $error("marker with unexpected error");

endmodule

bind coap_message_parser_top coap_checker u_checker (.*);

### tb/sv/coap_message_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Streams CoAP datagrams through the byte channel under random gaps and
// stalls, predicts the classification of every byte, and checks each result
// field by field. The register settings change between phases.
// ----------------------------------------------------------------------------
module coap_message_parser_top_tb;
  import coap_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned BYTES_PER_PHASE = 280;

  // One datagram byte as the driver presents it
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dgram_byte_t;

  // One result transaction, in port order
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] number;
    logic [15:0] length;
    logic [7:0]  ordinal;
    logic [3:0]  tkl;
    logic        done;
    err_t        err;
  } byte_class_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  byte_kind;
  logic [7:0]  byte_value;
  logic [15:0] option_number;
  logic [15:0] option_length;
  logic [7:0]  option_index;
  logic [3:0]  token_size;
  logic        message_done;
  logic [2:0]  error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  coap_message_parser_top u_top (.*);

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parse state mirror: a private copy of everything the block tracks
  // --------------------------------------------------------------------------
  logic [7:0]  capture_lim = 8'd0;
  logic [15:0] value_lim = 16'd12;

  phase_t      ph;
  logic [1:0]  hdr_pos;
  logic [3:0]  tok_left;
  logic [3:0]  tkl_held;
  logic [3:0]  dnib;
  logic [3:0]  lnib;
  logic [15:0] ext_acc;
  int unsigned opt_num;
  int unsigned cur_len;
  int unsigned val_left;
  int unsigned opt_cnt;
  int unsigned cur_ord;
  int unsigned ext_cnt;
  int unsigned delta_dec;
  int unsigned len_dec;
  int unsigned area_cnt;
  err_t        err_latched;

  // Expected results, oldest first
  byte_class_t class_due[$];
  dgram_byte_t byte_queue[$];
  logic [7:0]  frame[$];

  int unsigned mismatches = 0;
  int unsigned bytes_queued = 0;
  int unsigned frames_queued = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_off = 0;
  int unsigned stall_left = 0;
  logic [8:0]  kinds_seen = '0;
  logic [7:0]  errs_seen = '0;
  logic        took_byte = 1'b0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  function automatic void clear_parse();
    ph = PH_HDR;
    hdr_pos = '0;
    tok_left = '0;
    tkl_held = '0;
    dnib = '0;
    lnib = '0;
    ext_acc = '0;
    opt_num = 0;
    cur_len = 0;
    val_left = 0;
    opt_cnt = 0;
    cur_ord = 0;
    ext_cnt = 0;
    delta_dec = 0;
    len_dec = 0;
    area_cnt = 0;
    err_latched = ERR_NONE;
  endfunction

  // Latch the first error; the rest of the datagram is ignored
  function automatic void abort(err_t e);
    err_latched = e;
    ph = PH_IGNORE;
  endfunction

  function automatic void tally_area(int unsigned n);
    area_cnt = area_cnt + n;
    if (area_cnt > 32'h20000) area_cnt = 32'h20000;
  endfunction

  function automatic void begin_ext(logic [3:0] nib, phase_t nxt);
    ext_acc = '0;
    ext_cnt = (nib == NIB_EXT8) ? 1 : 2;
    ph = nxt;
  endfunction

  function automatic int unsigned ext_sum(logic [3:0] nib);
    return (ext_acc + ((nib == NIB_EXT8) ? EXT8_OFFSET : EXT16_OFFSET)) & 32'hFFFF;
  endfunction

  // Apply delta and length once the option header is fully known
  function automatic void finish_option(bit last);
    if (opt_num + delta_dec > 32'hFFFF || area_cnt > 32'hFFFF ||
        area_cnt + len_dec > 32'hFFFF) begin
      abort(ERR_OVERFLOW);
      return;
    end
    opt_num = (opt_num + delta_dec) & 32'hFFFF;
    cur_len = len_dec;
    if (last && len_dec != 0) begin
      abort(ERR_TRUNCATED);
      return;
    end
    if (cur_ord < capture_lim && len_dec > value_lim) begin
      abort(ERR_TOOLONG);
      return;
    end
    if (len_dec == 0) begin
      ph = PH_OPTHDR;
      return;
    end
    val_left = len_dec;
    tally_area(len_dec);
    ph = PH_VALUE;
  endfunction

  // The length nibble is looked at only once the delta is settled
  function automatic void after_delta_step(bit last, bit from_ext);
    if (lnib > NIB_DIRECT_MAX) begin
      if (lnib == NIB_RESERVED && !(last && from_ext)) begin
        abort(ERR_NIBBLE15);
        return;
      end
      if (last) begin
        abort(ERR_TRUNCATED);
        return;
      end
      begin_ext(lnib, PH_LEXT);
      return;
    end
    len_dec = 32'(lnib);
    finish_option(last);
  endfunction

  // Advance the mirror by one byte and return what the block should report
  function automatic byte_class_t classify_byte(logic [7:0] b, logic last);
    byte_class_t r;
    kind_t       k;
    k = KIND_PAYLOAD;
    case (ph)
      PH_HDR: begin
        k = (hdr_pos == 2'd0) ? KIND_HDR : (hdr_pos == 2'd1) ? KIND_CODE : KIND_MSGID;
        if (hdr_pos == 2'd0) tkl_held = b[3:0];
        if (hdr_pos < 2'd3) begin
          hdr_pos = hdr_pos + 2'd1;
          if (last) abort(ERR_SHORT);
        end else if (tkl_held > MAX_TOKEN_LEN) begin
          abort(ERR_TKL);
        end else if (tkl_held == 4'd0) begin
          ph = PH_OPTHDR;
        end else if (last) begin
          abort(ERR_SHORT);
        end else begin
          tok_left = tkl_held;
          ph = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        k = KIND_TOKEN;
        tok_left = tok_left - 4'd1;
        if (tok_left == 4'd0) ph = PH_OPTHDR;
        else if (last) abort(ERR_SHORT);
      end
      PH_OPTHDR: begin
        k = KIND_OPTHDR;
        tally_area(1);
        if (b == MARKER_BYTE) begin
          k = KIND_MARKER;
          if (last) abort(ERR_NOPAYLOAD);
          else ph = PH_PAYLOAD;
        end else begin
          cur_ord = opt_cnt;
          if (opt_cnt < 255) opt_cnt = opt_cnt + 1;
          dnib = b[7:4];
          lnib = b[3:0];
          if (last && dnib > NIB_DIRECT_MAX) begin
            abort(ERR_TRUNCATED);
          end else if (dnib == NIB_RESERVED) begin
            abort(ERR_NIBBLE15);
          end else if (dnib > NIB_DIRECT_MAX) begin
            begin_ext(dnib, PH_DEXT);
          end else begin
            delta_dec = 32'(dnib);
            after_delta_step(last, 1'b0);
          end
        end
      end
      PH_DEXT, PH_LEXT: begin
        k = KIND_OPTEXT;
        tally_area(1);
        ext_acc = {ext_acc[7:0], b};
        ext_cnt = (ext_cnt > 0) ? ext_cnt - 1 : 0;
        if (ext_cnt > 0) begin
          if (last) abort(ERR_TRUNCATED);
        end else if (ph == PH_DEXT) begin
          delta_dec = ext_sum(dnib);
          after_delta_step(last, 1'b1);
        end else begin
          len_dec = ext_sum(lnib);
          finish_option(last);
        end
      end
      PH_VALUE: begin
        k = KIND_OPTVAL;
        val_left = (val_left > 0) ? val_left - 1 : 0;
        if (val_left == 0) ph = PH_OPTHDR;
        else if (last) abort(ERR_TRUNCATED);
      end
      default: k = KIND_PAYLOAD;
    endcase
    r.kind = k;
    r.data = b;
    r.number = opt_num[15:0];
    r.length = cur_len[15:0];
    r.ordinal = cur_ord[7:0];
    r.tkl = tkl_held;
    r.done = last;
    r.err = err_latched;
    if (last) clear_parse();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Datagram construction
  // --------------------------------------------------------------------------
  function automatic void add_random(int unsigned n);
    repeat (n) frame.push_back(8'($urandom));
  endfunction

  function automatic logic [3:0] nibble_of(int unsigned v);
    if (v < 13) return v[3:0];
    if (v < 269) return NIB_EXT8;
    return 4'd14;
  endfunction

  function automatic void add_ext(int unsigned v);
    logic [15:0] x;
    if (v >= 269) begin
      x = 16'(v - 269);
      frame.push_back(x[15:8]);
      frame.push_back(x[7:0]);
    end else if (v >= 13) begin
      x = 16'(v - 13);
      frame.push_back(x[7:0]);
    end
  endfunction

  // Option header plus extensions; the caller appends the value bytes
  function automatic void add_opt_hdr(int unsigned delta, int unsigned len);
    frame.push_back({nibble_of(delta), nibble_of(len)});
    add_ext(delta);
    add_ext(len);
  endfunction

  // Move the current frame into the byte stream, flagging the final byte
  function automatic void send_frame();
    foreach (frame[i]) byte_queue.push_back({frame[i], i == frame.size() - 1});
    bytes_queued += frame.size();
    frames_queued++;
  endfunction

  // Mostly well-formed messages with random content; the rest is noise,
  // cut-short messages and messages with one byte overwritten.
  function automatic void build_random_frame();
    logic [7:0]  first;
    int unsigned tkl, nopt, delta, len, r, cut;
    frame.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_random($urandom_range(1, 10));
      return;
    end
    tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    first = 8'($urandom);
    first[3:0] = tkl[3:0];
    frame.push_back(first);
    add_random(3 + tkl);
    nopt = $urandom_range(0, 4);
    repeat (nopt) begin
      r = $urandom_range(0, 99);
      delta = (r < 70) ? $urandom_range(0, 12) :
              (r < 90) ? $urandom_range(13, 300) :
              (r < 98) ? $urandom_range(269, 3000) : $urandom_range(0, 65535);
      r = $urandom_range(0, 99);
      len = (r < 75) ? $urandom_range(0, 8) :
            (r < 97) ? $urandom_range(9, 30) : $urandom_range(269, 300);
      add_opt_hdr(delta, len);
      add_random(len);
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      frame.push_back(MARKER_BYTE);
      add_random($urandom_range(1, 12));
    end else if (r < 50) begin
      frame.push_back(MARKER_BYTE);
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end else if (r < 22) begin
      frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
    end
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // --------------------------------------------------------------------------
  // Register access: write, then read back and compare
  // --------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_CAPTURE_COUNT) ? {24'd0, val[7:0]} : {16'd0, val[15:0]};
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    // the write landed at the last rising edge; track it in the mirror
    if (idx == REG_CAPTURE_COUNT) capture_lim = val[7:0];
    else value_lim = val[15:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver: present the next byte after each transaction, with gaps
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else if (!data_valid || took_byte) begin
      if (hold_off > 0 || byte_queue.size() == 0) begin
        // drop valid for the gap, or when nothing is pending
        data_valid <= 1'b0;
        if (hold_off > 0) hold_off--;
      end else begin
        {data_byte, last_byte} <= byte_queue.pop_front();
        data_valid <= 1'b1;
        hold_off = pick_gap(calm_in);
      end
    end
  end

  // Result backpressure: stall bursts of random length between ready cycles
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap(calm_out);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted byte, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    byte_class_t want;
    if (rst) begin
      took_byte <= 1'b0;
    end else begin
      took_byte <= data_valid && !data_stall;
      // check before predicting so a premature result cannot match a new byte
      if (result_valid && !result_stall) begin
        results_checked++;
        if (class_due.size() == 0) begin
          $error("result transaction with no byte outstanding");
          mismatches++;
        end else begin
          want = class_due.pop_front();
          kinds_seen[want.kind] = 1'b1;
          errs_seen[want.err] = 1'b1;
          check_field("byte_kind", want.kind, byte_kind);
          check_field("byte_value", want.data, byte_value);
          check_field("option_number", want.number, option_number);
          check_field("option_length", want.length, option_length);
          check_field("option_index", want.ordinal, option_index);
          check_field("token_size", want.tkl, token_size);
          check_field("message_done", want.done, message_done);
          check_field("error_code", want.err, error_code);
        end
      end
      if (data_valid && !data_stall) class_due.push_back(classify_byte(data_byte, last_byte));
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               quiet_cycles, class_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, then phases of register settings and traffic
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  cc_set [PHASES];
    logic [15:0] vl_set [PHASES];
    int unsigned target;
    // reset values first, then a mix of extreme, middling and random settings
    cc_set = '{8'd0, 8'd255, 8'd2, 8'd255, 8'd0, 8'd1};
    vl_set = '{16'd12, 16'd0, 16'd8, 16'd65535, 16'd0, 16'd3};
    cc_set[4] = $urandom_range(0, 6);
    vl_set[4] = $urandom_range(0, 40);
    clear_parse();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // hold until the block is idle before touching the registers
      while (byte_queue.size() != 0 || data_valid || class_due.size() != 0) @(negedge clk);
      write_reg(REG_CAPTURE_COUNT, {24'd0, cc_set[p]});
      write_reg(REG_VALUE_LIMIT, {16'd0, vl_set[p]});
      @(posedge clk);
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);

      if (p == 0) begin
        // header cut after one byte
        frame = '{8'h5A};
        send_frame();
        // token length nine
        frame = '{8'h49, 8'h01, 8'h12, 8'h34};
        send_frame();
        // reserved length nibble with more bytes following
        frame = '{8'h40, 8'h01, 8'h00, 8'h01, 8'h1F, 8'h00};
        send_frame();
        // payload marker as the final byte
        frame = '{8'h40, 8'h01, 8'h00, 8'h02, 8'hFF};
        send_frame();
        // option value cut short
        frame = '{8'h40, 8'h01, 8'h00, 8'h03, 8'h12, 8'hAB};
        send_frame();
        // option number pushed past 65535
        frame = '{8'h40, 8'h01, 8'h00, 8'h04};
        add_opt_hdr(65535, 0);
        add_opt_hdr(1, 0);
        send_frame();
        // option area pushed past 65535 by a declared length
        frame = '{8'h40, 8'h01, 8'h00, 8'h05};
        add_opt_hdr(0, 65535);
        send_frame();
        // clean message: token, one option, marker and payload
        frame = '{8'h62, 8'h45, 8'hFF, 8'h00, 8'hFF, 8'h00,
                  8'h12, 8'h00, 8'hFF, 8'hFF, 8'hA5};
        send_frame();
      end

      target = bytes_queued + BYTES_PER_PHASE;
      while (bytes_queued < target) begin
        build_random_frame();
        send_frame();
      end
    end

    // drain, then allow the pipeline latency for any stray result
    while (byte_queue.size() != 0 || data_valid || class_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes in %0d datagrams over %0d register settings, %0d results checked",
             bytes_queued, frames_queued, PHASES, results_checked);
    $display("Byte kinds seen %b, error codes seen %b, mismatches %0d",
             kinds_seen, errs_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### coap_message_parser_top.f
rtl/core/coap_pkg.sv
rtl/core/coap_cfg_regs.sv
rtl/core/coap_step.sv
rtl/core/coap_message_parser_top.sv
rtl/core/coap_checker.sv
tb/sv/coap_message_parser_top_tb.sv
